// ===== rtl/chse_pkg.sv =====
package chse_pkg;

    // Coordinate and parameter formats.
    localparam int COORD_W   = 21;
    localparam int CFG_W     = 63;
    localparam int CFG_IDX_W = 3;
    localparam int T_FRAC    = 16;
    localparam int T_W       = T_FRAC + 1;

    // Hermite coefficient width: covers six times the largest cubic coefficient.
    localparam int COEF_W = 27;
    localparam int PROD_W = COEF_W + T_W + 1;
    localparam int ACC_W  = PROD_W + 3;
    localparam int VAL_W  = 32;
    localparam int ARC_W  = 31;

    // A tangent component always fits in SLOPE_W signed bits.
    localparam int SLOPE_W = 27;
    localparam int SQ_W    = 2 * SLOPE_W;
    localparam int ROOT_W  = SQ_W / 2;

    localparam int NODES    = 5;
    localparam int AXES     = 3;
    localparam int Q_FRAC   = 30;
    localparam int EVAL_LAT = 4;

    localparam logic [T_W-1:0]    T_ONE    = T_W'(1) << T_FRAC;
    localparam logic [T_W-1:0]    T_HALF   = T_W'(1) << (T_FRAC - 1);
    localparam logic [Q_FRAC-1:0] Q30_HALF = Q_FRAC'(1) << (Q_FRAC - 1);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_START_POS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_POS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_TAN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_TAN   = 3'd3;

    // Commands.
    localparam logic CMD_DERIV = 1'b0;
    localparam logic CMD_ARC   = 1'b1;

    // Derivative orders.
    localparam logic [2:0] ORD_POSITION = 3'd0;
    localparam logic [2:0] ORD_VELOCITY = 3'd1;
    localparam logic [2:0] ORD_ACCEL    = 3'd2;
    localparam logic [2:0] ORD_JERK     = 3'd3;

    // Gauss-Legendre nodes on [0,1] and weights, Q0.30.
    localparam logic [NODES-1:0][Q_FRAC-1:0] NODE_Q30 = {
        30'd1023372512, 30'd50369312, 30'd825959422, 30'd247782402, 30'd536870912
    };
    localparam logic [NODES-1:0][Q_FRAC-1:0] WEIGHT_Q30 = {
        30'd127199153, 30'd127199153, 30'd256961811, 30'd256961811, 30'd305419897
    };

    typedef struct packed {
        logic           cmd;
        logic [2:0]     order;
        logic [T_W-1:0] t;
    } item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] x_value;
        logic signed [VAL_W-1:0] y_value;
        logic signed [VAL_W-1:0] z_value;
        logic [ARC_W-1:0]        path_len;
        logic                    out_of_range;
    } result_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] a3;
        logic signed [COEF_W-1:0] a6;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] d;
    } coef_t;

endpackage

// ===== rtl/chse_eval.sv =====
module chse_eval (
    input  logic                             clk,
    input  logic [chse_pkg::T_W-1:0]         u,
    input  logic [2:0]                       order,
    input  chse_pkg::coef_t                  coef,
    output logic signed [chse_pkg::VAL_W-1:0] value
);

    localparam int PW = 2 * chse_pkg::T_W;
    localparam logic signed [chse_pkg::ACC_W-1:0] ACC_HALF =
        chse_pkg::ACC_W'(chse_pkg::T_HALF);

    logic [chse_pkg::T_W-1:0] u1_reg;
    logic [chse_pkg::T_W-1:0] u2_reg;
    logic [chse_pkg::T_W-1:0] t2_1_reg;
    logic [chse_pkg::T_W-1:0] t2_2_reg;
    logic [chse_pkg::T_W-1:0] t3_2_reg;
    logic [2:0]               ord1_reg;
    logic [2:0]               ord2_reg;

    logic signed [chse_pkg::PROD_W-1:0] p3_reg;
    logic signed [chse_pkg::PROD_W-1:0] p2_reg;
    logic signed [chse_pkg::PROD_W-1:0] p1_reg;
    logic signed [chse_pkg::COEF_W-1:0] e0_reg;
    logic signed [chse_pkg::VAL_W-1:0]  value_reg;

    logic [PW-1:0] usq;
    logic [PW-1:0] ucube;
    logic signed [chse_pkg::COEF_W-1:0] e3;
    logic signed [chse_pkg::COEF_W-1:0] e2;
    logic signed [chse_pkg::COEF_W-1:0] e1;
    logic signed [chse_pkg::COEF_W-1:0] e0;
    logic signed [chse_pkg::PROD_W-1:0] p3_next;
    logic signed [chse_pkg::PROD_W-1:0] p2_next;
    logic signed [chse_pkg::PROD_W-1:0] p1_next;
    logic signed [chse_pkg::ACC_W-1:0]  acc;

    // Powers of t, each rounded half up.
    assign usq   = PW'(u) * PW'(u) + PW'(chse_pkg::T_HALF);
    assign ucube = PW'(t2_1_reg) * PW'(u1_reg) + PW'(chse_pkg::T_HALF);

    always_comb
    begin
        e3 = '0;
        e2 = '0;
        e1 = '0;
        e0 = '0;
        case (ord2_reg)
            chse_pkg::ORD_POSITION:
            begin
                e3 = coef.a;
                e2 = coef.b;
                e1 = coef.c;
                e0 = coef.d;
            end
            chse_pkg::ORD_VELOCITY:
            begin
                e2 = coef.a3;
                e1 = coef.b2;
                e0 = coef.c;
            end
            chse_pkg::ORD_ACCEL:
            begin
                e1 = coef.a6;
                e0 = coef.b2;
            end
            chse_pkg::ORD_JERK:
            begin
                e0 = coef.a6;
            end
            default:
            begin
                e0 = '0;
            end
        endcase
        p3_next = chse_pkg::PROD_W'(e3) * chse_pkg::PROD_W'($signed({1'b0, t3_2_reg}));
        p2_next = chse_pkg::PROD_W'(e2) * chse_pkg::PROD_W'($signed({1'b0, t2_2_reg}));
        p1_next = chse_pkg::PROD_W'(e1) * chse_pkg::PROD_W'($signed({1'b0, u2_reg}));
    end

    // The sum is exact; one arithmetic shift gives round half up to Q.0, a whole number.
    assign acc = chse_pkg::ACC_W'(p3_reg) + chse_pkg::ACC_W'(p2_reg)
               + chse_pkg::ACC_W'(p1_reg)
               + (chse_pkg::ACC_W'(e0_reg) <<< chse_pkg::T_FRAC) + ACC_HALF;

    always_ff @(posedge clk)
    begin
        u1_reg    <= u;
        ord1_reg  <= order;
        t2_1_reg  <= chse_pkg::T_W'(usq >> chse_pkg::T_FRAC);
        u2_reg    <= u1_reg;
        ord2_reg  <= ord1_reg;
        t2_2_reg  <= t2_1_reg;
        t3_2_reg  <= chse_pkg::T_W'(ucube >> chse_pkg::T_FRAC);
        p3_reg    <= p3_next;
        p2_reg    <= p2_next;
        p1_reg    <= p1_next;
        e0_reg    <= e0;
        value_reg <= chse_pkg::VAL_W'(acc >>> chse_pkg::T_FRAC);
    end

    assign value = value_reg;

endmodule

// ===== rtl/chse_isqrt.sv =====
module chse_isqrt (
    input  logic                        clk,
    input  logic [chse_pkg::SQ_W-1:0]   radicand,
    output logic [chse_pkg::ROOT_W-1:0] root
);

    localparam int RW    = chse_pkg::ROOT_W;
    localparam int SW    = chse_pkg::SQ_W;
    localparam int REM_W = RW + 2;
    localparam int TRY_W = REM_W + 2;

    logic [SW-1:0]    rad_reg  [RW];
    logic [REM_W-1:0] rem_reg  [RW];
    logic [RW-1:0]    root_reg [RW];
    logic [SW-1:0]    rad_next  [RW];
    logic [REM_W-1:0] rem_next  [RW];
    logic [RW-1:0]    root_next [RW];

    // One result bit per stage: bring down two radicand bits and try root*4+1.
    always_comb
    begin : digit_stages
        logic [SW-1:0]    rad_in;
        logic [REM_W-1:0] rem_in;
        logic [RW-1:0]    root_in;
        logic [TRY_W-1:0] rem_sh;
        logic [TRY_W-1:0] trial;
        for (int s = 0; s < RW; s++)
        begin
            if (s == 0)
            begin
                rad_in  = radicand;
                rem_in  = '0;
                root_in = '0;
            end
            else
            begin
                rad_in  = rad_reg[s-1];
                rem_in  = rem_reg[s-1];
                root_in = root_reg[s-1];
            end
            rem_sh = {rem_in, rad_in[SW-1 -: 2]};
            trial  = TRY_W'({root_in, 2'b01});
            if (rem_sh >= trial)
            begin
                rem_next[s]  = REM_W'(rem_sh - trial);
                root_next[s] = {root_in[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next[s]  = REM_W'(rem_sh);
                root_next[s] = {root_in[RW-2:0], 1'b0};
            end
            rad_next[s] = rad_in << 2;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < RW; s++)
        begin
            rad_reg[s]  <= rad_next[s];
            rem_reg[s]  <= rem_next[s];
            root_reg[s] <= root_next[s];
        end
    end

    assign root = root_reg[RW-1];

endmodule

// ===== rtl/cubic_hermite_segment_eval_core.sv =====
// Throughput: one item per cycle; busy is never raised and done cannot be held off.
// Depth is set by the 27-stage square root on the arc-length path; derivative words
// are computed late in the pipe so that both commands leave in order.
// Reset clears the four configuration registers to zero and empties the pipeline.
module cubic_hermite_segment_eval_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  chse_pkg::item_t                   item,
    output logic                              done,
    output chse_pkg::result_t                 result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [chse_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [chse_pkg::CFG_W-1:0]        cfg_data
);

    localparam int NODES  = chse_pkg::NODES;
    localparam int AXES   = chse_pkg::AXES;
    localparam int T_W    = chse_pkg::T_W;
    localparam int COEF_W = chse_pkg::COEF_W;
    localparam int COORD_W = chse_pkg::COORD_W;

    // Pipeline stage numbers, counted from the input register.
    localparam int D_STAGE     = 1 + chse_pkg::EVAL_LAT;
    localparam int SUM_STAGE   = D_STAGE + 2;
    localparam int ROOT_STAGE  = SUM_STAGE + chse_pkg::ROOT_W;
    localparam int SCALE_STAGE = ROOT_STAGE + 2;
    localparam int LENP_STAGE  = SCALE_STAGE + 1;
    localparam int DER_IN      = LENP_STAGE - chse_pkg::EVAL_LAT;
    localparam int META_N      = LENP_STAGE + 1;

    localparam int NM_W  = chse_pkg::Q_FRAC + T_W;
    localparam int WP_W  = chse_pkg::Q_FRAC + chse_pkg::ROOT_W;
    localparam int WS_W  = WP_W + 3;
    localparam int SC_W  = WS_W - chse_pkg::Q_FRAC;
    localparam int LP_W  = SC_W + T_W;
    localparam int LEN_W = LP_W + 1 - chse_pkg::T_FRAC;
    localparam logic [LEN_W-1:0] ARC_MAX = LEN_W'({chse_pkg::ARC_W{1'b1}});

    typedef struct packed {
        logic           cmd;
        logic [2:0]     order;
        logic [T_W-1:0] t;
        logic           oor;
    } meta_t;

    logic accept;

    logic [chse_pkg::CFG_W-1:0] start_pos_reg;
    logic [chse_pkg::CFG_W-1:0] end_pos_reg;
    logic [chse_pkg::CFG_W-1:0] start_tan_reg;
    logic [chse_pkg::CFG_W-1:0] end_tan_reg;

    logic signed [COEF_W-1:0] a_reg [AXES];
    logic signed [COEF_W-1:0] b_reg [AXES];
    logic signed [COEF_W-1:0] c_reg [AXES];
    logic signed [COEF_W-1:0] d_reg [AXES];
    logic signed [COEF_W-1:0] a_next [AXES];
    logic signed [COEF_W-1:0] b_next [AXES];
    logic signed [COEF_W-1:0] c_next [AXES];
    logic signed [COEF_W-1:0] d_next [AXES];
    chse_pkg::coef_t          coef_reg [AXES];

    logic  meta_valid_reg [META_N];
    meta_t meta_reg       [META_N];

    logic [T_W-1:0]                    node_reg [NODES];
    logic signed [chse_pkg::VAL_W-1:0] slope    [NODES][AXES];
    logic [chse_pkg::SQ_W-1:0]         sqp_next [NODES][AXES];
    logic [chse_pkg::SQ_W-1:0]         sqp_reg  [NODES][AXES];
    logic [chse_pkg::SQ_W-1:0]         sq_reg   [NODES];
    logic [chse_pkg::ROOT_W-1:0]       root     [NODES];
    logic [WP_W-1:0]                   wp_reg   [NODES];
    logic [SC_W-1:0]                   scaled_reg;
    logic [LP_W-1:0]                   lenp_reg;
    logic signed [chse_pkg::VAL_W-1:0] deriv    [AXES];

    logic [WS_W-1:0]      wsum;
    logic [LP_W:0]        len_round;
    logic [LEN_W-1:0]     len_full;
    chse_pkg::result_t    result_next;
    chse_pkg::result_t    result_reg;
    logic                 done_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Configuration registers; indexes past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pos_reg <= '0;
            end_pos_reg   <= '0;
            start_tan_reg <= '0;
            end_tan_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                chse_pkg::REG_START_POS: start_pos_reg <= cfg_data;
                chse_pkg::REG_END_POS:   end_pos_reg   <= cfg_data;
                chse_pkg::REG_START_TAN: start_tan_reg <= cfg_data;
                chse_pkg::REG_END_TAN:   end_tan_reg   <= cfg_data;
                default:                 start_pos_reg <= start_pos_reg;
            endcase
        end
    end

    // Hermite coefficients per axis. After a write they pass through a_reg..d_reg and
    // then coef_reg, and settle before an item reaches the multipliers.
    always_comb
    begin : coef_calc
        logic signed [COEF_W-1:0] ep0;
        logic signed [COEF_W-1:0] ep1;
        logic signed [COEF_W-1:0] em0;
        logic signed [COEF_W-1:0] em1;
        logic signed [COEF_W-1:0] dp;
        for (int k = 0; k < AXES; k++)
        begin
            ep0 = COEF_W'($signed(start_pos_reg[k*COORD_W +: COORD_W]));
            ep1 = COEF_W'($signed(end_pos_reg[k*COORD_W +: COORD_W]));
            em0 = COEF_W'($signed(start_tan_reg[k*COORD_W +: COORD_W]));
            em1 = COEF_W'($signed(end_tan_reg[k*COORD_W +: COORD_W]));
            dp  = ep1 - ep0;
            a_next[k] = em0 + em1 - (dp <<< 1);
            b_next[k] = (dp <<< 1) + dp - (em0 <<< 1) - em1;
            c_next[k] = em0;
            d_next[k] = ep0;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < AXES; k++)
        begin
            a_reg[k]       <= a_next[k];
            b_reg[k]       <= b_next[k];
            c_reg[k]       <= c_next[k];
            d_reg[k]       <= d_next[k];
            coef_reg[k].a  <= a_reg[k];
            coef_reg[k].a3 <= a_reg[k] + (a_reg[k] <<< 1);
            coef_reg[k].a6 <= (a_reg[k] <<< 2) + (a_reg[k] <<< 1);
            coef_reg[k].b  <= b_reg[k];
            coef_reg[k].b2 <= b_reg[k] <<< 1;
            coef_reg[k].c  <= c_reg[k];
            coef_reg[k].d  <= d_reg[k];
        end
    end

    // Item fields travel down the whole pipe beside their valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < META_N; s++)
            begin
                meta_valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            meta_valid_reg[0] <= accept;
            for (int s = 1; s < META_N; s++)
            begin
                meta_valid_reg[s] <= meta_valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        meta_reg[0].cmd   <= item.cmd;
        meta_reg[0].order <= item.order;
        meta_reg[0].t     <= item.t;
        meta_reg[0].oor   <= item.t > chse_pkg::T_ONE;
        for (int s = 1; s < META_N; s++)
        begin
            meta_reg[s] <= meta_reg[s-1];
        end
    end

    // Quadrature nodes: round(node * t).
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NODES; i++)
        begin
            node_reg[i] <= T_W'((NM_W'(chse_pkg::NODE_Q30[i]) * NM_W'(meta_reg[0].t)
                                 + NM_W'(chse_pkg::Q30_HALF)) >> chse_pkg::Q_FRAC);
        end
    end

    for (genvar gi = 0; gi < NODES; gi++)
    begin : g_node
        for (genvar gk = 0; gk < AXES; gk++)
        begin : g_axis
            chse_eval u_eval (
                .clk   (clk),
                .u     (node_reg[gi]),
                .order (chse_pkg::ORD_VELOCITY),
                .coef  (coef_reg[gk]),
                .value (slope[gi][gk])
            );
        end

        chse_isqrt u_isqrt (
            .clk      (clk),
            .radicand (sq_reg[gi]),
            .root     (root[gi])
        );
    end

    for (genvar gk = 0; gk < AXES; gk++)
    begin : g_deriv
        chse_eval u_eval (
            .clk   (clk),
            .u     (meta_reg[DER_IN].t),
            .order (meta_reg[DER_IN].order),
            .coef  (coef_reg[gk]),
            .value (deriv[gk])
        );
    end

    // Squares of the tangent components; the low bits of a slope hold it exactly.
    always_comb
    begin : square_calc
        logic signed [chse_pkg::SQ_W-1:0] sx;
        for (int i = 0; i < NODES; i++)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                sx = chse_pkg::SQ_W'($signed(slope[i][k][chse_pkg::SLOPE_W-1:0]));
                sqp_next[i][k] = sx * sx;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NODES; i++)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                sqp_reg[i][k] <= sqp_next[i][k];
            end
            sq_reg[i] <= sqp_reg[i][0] + sqp_reg[i][1] + sqp_reg[i][2];
            wp_reg[i] <= WP_W'(chse_pkg::WEIGHT_Q30[i]) * WP_W'(root[i]);
        end
    end

    assign wsum = WS_W'(wp_reg[0]) + WS_W'(wp_reg[1]) + WS_W'(wp_reg[2])
                + WS_W'(wp_reg[3]) + WS_W'(wp_reg[4]) + WS_W'(chse_pkg::Q30_HALF);

    always_ff @(posedge clk)
    begin
        scaled_reg <= SC_W'(wsum >> chse_pkg::Q_FRAC);
        lenp_reg   <= LP_W'(scaled_reg) * LP_W'(meta_reg[SCALE_STAGE].t);
    end

    assign len_round = (LP_W + 1)'(lenp_reg) + (LP_W + 1)'(chse_pkg::T_HALF);
    assign len_full  = LEN_W'(len_round >> chse_pkg::T_FRAC);

    // Derivative words already fit the 32-bit result range exactly.
    always_comb
    begin
        result_next = '0;
        if (meta_reg[LENP_STAGE].oor)
        begin
            result_next.out_of_range = 1'b1;
        end
        else if (meta_reg[LENP_STAGE].cmd == chse_pkg::CMD_DERIV)
        begin
            result_next.x_value = deriv[0];
            result_next.y_value = deriv[1];
            result_next.z_value = deriv[2];
        end
        else if (len_full > ARC_MAX)
        begin
            result_next.path_len = chse_pkg::ARC_W'(ARC_MAX);
        end
        else
        begin
            result_next.path_len = chse_pkg::ARC_W'(len_full);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= meta_valid_reg[LENP_STAGE];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/chse_checker.sv =====
module chse_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input chse_pkg::item_t   item,
    input logic              done,
    input chse_pkg::result_t result
);

    localparam int LATENCY = 39;

    // Every done word belongs to a start taken a fixed time earlier.
    a_done_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("done word without a matching start");

    a_range_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.out_of_range == ($past(item.t, LATENCY) > chse_pkg::T_ONE)))
        else $error("out_of_range does not match t of the item");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.out_of_range |->
            result.x_value == '0 && result.y_value == '0 && result.z_value == '0
            && result.path_len == '0)
        else $error("out-of-range word carries data");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.path_len != '0) |->
            result.x_value == '0 && result.y_value == '0 && result.z_value == '0)
        else $error("arc length and derivative both set");

endmodule

bind cubic_hermite_segment_eval_core chse_checker u_chse_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);
